### sv/dsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_pkg: shared types for the set dueling insertion unit
// Controller states, command and status structs, role codes.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam logic [1:0] ROLE_FOLLOWER = 2'd0;
  localparam logic [1:0] ROLE_BIMODAL  = 2'd1;
  localparam logic [1:0] ROLE_LRU      = 2'd2;

  localparam logic [6:0] BIP_PERCENT = 7'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_RANK_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;    // latch request
    logic clear_step; // clear one rank row and/or leader entry
    logic load_wr;    // write leader entry
    logic scan_start;
    logic scan_step;
    logic decide;     // update selector, choose promote
    logic rank_rd;    // issue rank row read
    logic rank_cmp;   // register old rank of target way
    logic rank_wr;    // write updated row
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic cpu_ok;
    logic is_load;
    logic do_promote;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

### sv/dsd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_ram: generic single port RAM
// One address per cycle, written when we is high; registered read data.
// ----------------------------------------------------------------------------
module dsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

`default_nettype wire

### sv/dsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_ctrl: sequencer for the insertion unit
// Clearing pass, leader load, leader scan, rank read-modify-write.
// ----------------------------------------------------------------------------
module dsd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  dsd_pkg::status_t sts,
  output dsd_pkg::cmd_t       cmd
);
  import dsd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (sts.clear_last) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (!sts.cpu_ok || sts.is_load) state_next = ST_DONE;
        else state_next = ST_SCAN;
      end
      ST_SCAN:      if (sts.scan_last) state_next = ST_SCAN_LAST;
      ST_SCAN_LAST: state_next = ST_DECIDE;
      ST_DECIDE:    state_next = ST_RANK_RD;
      ST_RANK_RD:   state_next = sts.do_promote ? ST_RANK_CMP : ST_DONE;
      ST_RANK_CMP:  state_next = ST_RANK_WR;
      ST_RANK_WR:   state_next = ST_DONE;
      ST_DONE:      if (!sts.out_busy) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.load_wr = sts.cpu_ok && sts.is_load;
        cmd.scan_start = 1'b1;
      end
      ST_SCAN:      cmd.scan_step = 1'b1;
      ST_SCAN_LAST: cmd.scan_step = 1'b1;
      ST_DECIDE:    cmd.decide = 1'b1;
      ST_RANK_RD:   cmd.rank_rd = 1'b1;
      ST_RANK_CMP:  cmd.rank_cmp = 1'b1;
      ST_RANK_WR:   cmd.rank_wr = 1'b1;
      ST_DONE:      cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_LOAD) else $error("capture did not start item");
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> in_stall) else $error("accepted during clear");
  a_wr_after_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.rank_wr |-> $past(cmd.rank_cmp)) else $error("rank write out of order");
endmodule

`default_nettype wire

### sv/dsd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_datapath: leader table, selectors, rank store and output register
// Leader table is a RAM scanned one slot a cycle; rank rows are held in one RAM.
// ----------------------------------------------------------------------------
module dsd_datapath #(
  parameter int CPU_COUNT          = 4,
  parameter int SET_COUNT          = 2048,
  parameter int WAY_COUNT          = 16,
  parameter int LEADERS_PER_POLICY = 64,
  parameter int SELECTOR_BITS      = 10
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  dsd_pkg::cmd_t   cmd,
  output dsd_pkg::status_t      sts,
  input  wire                   action,
  input  wire  [1:0]            cpu_id,
  input  wire  [10:0]           set_index,
  input  wire  [3:0]            way_index,
  input  wire                   hit_flag,
  input  wire                   is_writeback,
  input  wire  [6:0]            chance_draw,
  input  wire  [6:0]            leader_slot,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  promoted,
  output logic [1:0]            set_role,
  output logic [9:0]            selector_value
);
  import dsd_pkg::*;

  localparam int GROUP  = 2 * LEADERS_PER_POLICY;
  localparam int GB     = $clog2(GROUP);
  localparam int CB     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int TDEPTH = (CPU_COUNT > 1) ? CPU_COUNT * GROUP : 2 * GROUP;
  localparam int TB     = $clog2(TDEPTH);
  localparam int SB     = $clog2(SET_COUNT);
  localparam int WB     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int ROWW   = WAY_COUNT * WB;
  localparam int CLR_N  = (SET_COUNT > TDEPTH) ? SET_COUNT : TDEPTH;
  localparam int CLRB   = $clog2(CLR_N);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF =
    SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);

  // request registers
  logic        r_action, r_hit, r_wb;
  logic [1:0]  r_cpu;
  logic [10:0] r_set;
  logic [3:0]  r_way;
  logic [6:0]  r_draw, r_slot;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_action <= action;  r_cpu <= cpu_id; r_set <= set_index;
      r_way <= way_index;  r_hit <= hit_flag; r_wb <= is_writeback;
      r_draw <= chance_draw; r_slot <= leader_slot;
    end
  end

  logic cpu_ok, set_ok, way_ok, slot_ok;
  assign cpu_ok  = 32'(r_cpu) < CPU_COUNT;
  assign set_ok  = 32'(r_set) < SET_COUNT;
  assign way_ok  = 32'(r_way) < WAY_COUNT;
  assign slot_ok = 32'(r_slot) < GROUP;
  logic [CB-1:0] cpu_ix;
  assign cpu_ix = CB'(r_cpu);

  // clearing pass after reset covers both the rank rows and the leader table
  logic [CLRB-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
  end
  assign sts.clear_last = clr_cnt == CLRB'(CLR_N - 1);

  // leader table: valid bit and set number in RAM
  logic [GB:0]       scan_cnt;
  logic [GB-1:0]     scan_slot_d;
  logic [TB-1:0]     t_addr;
  logic [11:0]       t_rdata, t_wdata;
  logic              t_we;

  assign t_we = (cmd.load_wr && slot_ok) ||
                (cmd.clear_step && 32'(clr_cnt) < TDEPTH);
  assign t_wdata = cmd.clear_step ? 12'd0 : {1'b1, r_set};
  always_comb begin
    if (cmd.clear_step) t_addr = TB'(clr_cnt);
    else if (cmd.load_wr) t_addr = TB'(32'(cpu_ix) * GROUP + 32'(r_slot));
    else t_addr = TB'(32'(cpu_ix) * GROUP + 32'(scan_cnt[GB-1:0]));
  end

  dsd_ram #(.WIDTH(12), .DEPTH(TDEPTH)) u_leader (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  logic [1:0] role;
  logic       found;
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt <= '0; found <= 1'b0; role <= ROLE_FOLLOWER;
    end else if (cmd.scan_step) begin
      scan_cnt    <= scan_cnt + 1'b1;
      scan_slot_d <= scan_cnt[GB-1:0];
      if (scan_cnt != '0 && !found && t_rdata[11] && t_rdata[10:0] == r_set) begin
        found <= 1'b1;
        role  <= (32'(scan_slot_d) < LEADERS_PER_POLICY) ? ROLE_BIMODAL : ROLE_LRU;
      end
    end
  end
  assign sts.scan_last = scan_cnt == (GB+1)'(GROUP - 1);

  // selectors
  logic [SELECTOR_BITS-1:0] sel [CPU_COUNT];
  logic [SELECTOR_BITS-1:0] cur_sel;
  assign cur_sel = sel[cpu_ix];
  logic do_promote;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CPU_COUNT; i++) sel[i] <= '0;
    end else if (cmd.decide && !r_hit) begin
      if (role == ROLE_LRU && cur_sel != SEL_MAX) sel[cpu_ix] <= cur_sel + 1'b1;
      else if (role == ROLE_BIMODAL && cur_sel != '0) sel[cpu_ix] <= cur_sel - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (r_hit) do_promote <= !r_wb;
      else if (role == ROLE_LRU) do_promote <= 1'b1;
      else if (role == ROLE_BIMODAL || cur_sel >= SEL_HALF)
        do_promote <= r_draw < BIP_PERCENT;
      else do_promote <= 1'b1;
    end
  end
  logic promote_ok;
  assign promote_ok = do_promote && set_ok && way_ok;

  // rank store, one row per set
  logic [SB-1:0]   r_addr;
  logic [ROWW-1:0] r_wdata, r_rdata, reset_row, new_row;
  logic            r_we;
  logic [WB-1:0]   mine;

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) reset_row[w*WB +: WB] = WB'(w);
  end

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (WB'(w) == r_way[WB-1:0]) new_row[w*WB +: WB] = '0;
      else if (r_rdata[w*WB +: WB] < mine)
        new_row[w*WB +: WB] = r_rdata[w*WB +: WB] + 1'b1;
      else new_row[w*WB +: WB] = r_rdata[w*WB +: WB];
    end
  end

  assign r_we    = (cmd.clear_step && 32'(clr_cnt) < SET_COUNT) ||
                   (cmd.rank_wr && promote_ok);
  assign r_addr  = cmd.clear_step ? SB'(clr_cnt) : r_set[SB-1:0];
  assign r_wdata = cmd.clear_step ? reset_row : new_row;

  dsd_ram #(.WIDTH(ROWW), .DEPTH(SET_COUNT)) u_ranks (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rank_cmp) mine <= r_rdata[r_way[WB-1:0]*WB +: WB];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      promoted       <= cpu_ok && !r_action && promote_ok;
      set_role       <= (cpu_ok && !r_action) ? role : ROLE_FOLLOWER;
      selector_value <= cpu_ok ? 10'(cur_sel) : 10'd0;
    end
  end

  assign sts.cpu_ok     = cpu_ok;
  assign sts.is_load    = r_action;
  assign sts.do_promote = promote_ok;
  assign sts.out_busy   = out_valid && out_stall;

  a_role_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> set_role != 2'd3) else $error("bad role code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_wb_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && r_hit && r_wb |=> !promoted) else $error("writeback hit promoted");
endmodule

`default_nettype wire

### sv/dip_set_dueling_insertion_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dip_set_dueling_insertion_unit: set dueling LLC insertion policy
// Keeps per-CPU leader tables and selectors and per-set LRU ranks.
// ----------------------------------------------------------------------------
// Usage: present a request on in_valid with its fields; it is taken on a
// cycle where in_valid is high and in_stall low. Each request gives one
// result on out_valid/out_stall. A load request writes a leader slot and
// goes straight to its result. An access request scans the CPU's
// 2*LEADERS_PER_POLICY leader slots one per cycle from the leader RAM,
// then updates the selector and, when it promotes, does a read-modify-write
// of the set's rank row. One request is in flight at a time.
// After reset the rank rows and leader table are swept one entry per cycle
// (max of SET_COUNT and 2*LEADERS_PER_POLICY*CPU_COUNT entries, 2048 at
// defaults) with in_stall high. A stalled result holds in the output
// register; the following request runs and then waits in ST_DONE until it
// leaves.
// ----------------------------------------------------------------------------
module dip_set_dueling_insertion_unit #(
  parameter int CPU_COUNT          = 4,
  parameter int SET_COUNT          = 2048,
  parameter int WAY_COUNT          = 16,
  parameter int LEADERS_PER_POLICY = 64,
  parameter int SELECTOR_BITS      = 10
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         action,
  input  wire  [1:0]  cpu_id,
  input  wire  [10:0] set_index,
  input  wire  [3:0]  way_index,
  input  wire         hit_flag,
  input  wire         is_writeback,
  input  wire  [6:0]  chance_draw,
  input  wire  [6:0]  leader_slot,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        promoted,
  output logic [1:0]  set_role,
  output logic [9:0]  selector_value
);
  import dsd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  dsd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  dsd_datapath #(
    .CPU_COUNT(CPU_COUNT), .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT),
    .LEADERS_PER_POLICY(LEADERS_PER_POLICY), .SELECTOR_BITS(SELECTOR_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(action), .cpu_id(cpu_id), .set_index(set_index),
    .way_index(way_index), .hit_flag(hit_flag), .is_writeback(is_writeback),
    .chance_draw(chance_draw), .leader_slot(leader_slot),
    .out_valid(out_valid), .out_stall(out_stall), .promoted(promoted),
    .set_role(set_role), .selector_value(selector_value)
  );
endmodule

`default_nettype wire

### tb/tb_dip_set_dueling_insertion_unit.sv
// ----------------------------------------------------------------------------
// tb_dip_set_dueling_insertion_unit: testbench for the set dueling unit
// Drives load and access requests with random idle and stall patterns.
// A behavioral model predicts promoted, role and selector per request.
// Every result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_dip_set_dueling_insertion_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dsd_pkg::*;

  localparam int NCPU = 4;
  localparam int NSET = 2048;
  localparam int NWAY = 16;
  localparam int NLEAD = 64;
  localparam int GROUP = 2 * NLEAD;
  localparam logic [9:0] SEL_TOP = 10'd1023;
  localparam logic [9:0] SEL_MID = 10'd512;
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic       action;
    logic [1:0] cpu;
    logic [10:0] set;
    logic [3:0] way;
    logic       hit;
    logic       wb;
    logic [6:0] draw;
    logic [6:0] slot;
  } req_t;

  typedef struct packed {
    logic       promoted;
    logic [1:0] role;
    logic [9:0] sel;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [1:0] cpu_id = '0;
  logic [10:0] set_index = '0;
  logic [3:0] way_index = '0;
  logic hit_flag = 1'b0;
  logic is_writeback = 1'b0;
  logic [6:0] chance_draw = '0;
  logic [6:0] leader_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic promoted;
  logic [1:0] set_role;
  logic [9:0] selector_value;

  dip_set_dueling_insertion_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .cpu_id(cpu_id), .set_index(set_index),
    .way_index(way_index), .hit_flag(hit_flag), .is_writeback(is_writeback),
    .chance_draw(chance_draw), .leader_slot(leader_slot),
    .out_valid(out_valid), .out_stall(out_stall), .promoted(promoted),
    .set_role(set_role), .selector_value(selector_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic        lead_ok [NCPU*GROUP];
  logic [10:0] lead_set [NCPU*GROUP];
  logic [9:0]  selector [NCPU];
  logic [3:0]  rank [NSET][NWAY];
  res_t        pending_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  logic [10:0] recent_leaders[$];

  function automatic logic [1:0] lookup_role(logic [1:0] c, logic [10:0] s);
    for (int i = 0; i < GROUP; i++)
      if (lead_ok[c*GROUP+i] && lead_set[c*GROUP+i] == s)
        return (i < NLEAD) ? ROLE_BIMODAL : ROLE_LRU;
    return ROLE_FOLLOWER;
  endfunction

  function automatic logic move_to_mru(logic [10:0] s, logic [3:0] w);
    logic [3:0] mine;
    mine = rank[s][w];
    for (int i = 0; i < NWAY; i++)
      if (rank[s][i] < mine) rank[s][i]++;
    rank[s][w] = '0;
    return 1'b1;
  endfunction

  function automatic res_t predict_insertion(req_t r);
    res_t o;
    o = '0;
    if (r.action == ACT_LOAD) begin
      if (r.slot < GROUP) begin
        lead_set[r.cpu*GROUP+r.slot] = r.set;
        lead_ok[r.cpu*GROUP+r.slot] = 1'b1;
      end
    end else begin
      o.role = lookup_role(r.cpu, r.set);
      if (r.hit) begin
        if (!r.wb) o.promoted = move_to_mru(r.set, r.way);
      end else if (o.role == ROLE_LRU) begin
        if (selector[r.cpu] < SEL_TOP) selector[r.cpu]++;
        o.promoted = move_to_mru(r.set, r.way);
      end else if (o.role == ROLE_BIMODAL) begin
        if (selector[r.cpu] > 0) selector[r.cpu]--;
        if (r.draw < BIP_PERCENT) o.promoted = move_to_mru(r.set, r.way);
      end else if (selector[r.cpu] >= SEL_MID) begin
        if (r.draw < BIP_PERCENT) o.promoted = move_to_mru(r.set, r.way);
      end else begin
        o.promoted = move_to_mru(r.set, r.way);
      end
    end
    o.sel = selector[r.cpu];
    return o;
  endfunction

  task automatic send_request(req_t r);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_valid <= 1'b1;
    {action, cpu_id, set_index, way_index, hit_flag, is_writeback,
     chance_draw, leader_slot} <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_insertion(r));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result p=%0d r=%0d s=%0d", $realtime,
                 promoted, set_role, selector_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (promoted !== want.promoted) begin
          $display("%0t: promoted exp %0d got %0d", $realtime, want.promoted, promoted);
          errors++;
        end
        if (set_role !== want.role) begin
          $display("%0t: set_role exp %0d got %0d", $realtime, want.role, set_role);
          errors++;
        end
        if (selector_value !== want.sel) begin
          $display("%0t: selector_value exp %0d got %0d", $realtime, want.sel,
                   selector_value);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic req_t load_req(logic [1:0] c, logic [6:0] sl, logic [10:0] s);
    req_t r;
    r = '0;
    r.action = ACT_LOAD;
    r.cpu = c;
    r.slot = sl;
    r.set = s;
    r.way = 4'($urandom);
    r.draw = 7'($urandom);
    return r;
  endfunction

  function automatic req_t access_req(logic [1:0] c, logic [10:0] s, logic [3:0] w,
                                      logic h, logic wb, logic [6:0] d);
    req_t r;
    r.action = ACT_ACCESS;
    r.cpu = c;
    r.set = s;
    r.way = w;
    r.hit = h;
    r.wb = wb;
    r.draw = d;
    r.slot = 7'($urandom);
    return r;
  endfunction

  // random request: mostly accesses to known leader sets or a small pool
  function automatic req_t random_req();
    req_t r;
    logic [10:0] s;
    int k;
    k = $urandom_range(99);
    if (k < 12) begin
      s = 11'($urandom);
      recent_leaders.push_back(s);
      if (recent_leaders.size() > 40) void'(recent_leaders.pop_front());
      return load_req(2'($urandom), ($urandom_range(9) == 0) ? 7'($urandom)
                      : 7'($urandom_range(GROUP-1)), s);
    end
    if (k < 60 && recent_leaders.size() > 0)
      s = recent_leaders[$urandom_range(recent_leaders.size()-1)];
    else if (k < 85)
      s = 11'($urandom_range(15));
    else
      s = 11'($urandom);
    r = access_req(2'($urandom), s, 4'($urandom), $urandom_range(2) == 0,
                   1'($urandom_range(1)), $urandom_range(3) == 0 ? 7'($urandom)
                   : 7'($urandom_range(99)));
    return r;
  endfunction

  task automatic test_directed();
    send_request(access_req(2'd0, 11'd0, 4'd15, 1'b0, 1'b0, 7'd0));
    send_request(access_req(2'd3, 11'd2047, 4'd0, 1'b1, 1'b0, 7'd99));
    send_request(access_req(2'd1, 11'd2047, 4'd7, 1'b1, 1'b1, 7'd127));
    send_request(load_req(2'd0, 7'd0, 11'd100));
    send_request(load_req(2'd0, 7'd127, 11'd200));
    send_request(load_req(2'd0, 7'd64, 11'd100));
    send_request(load_req(2'd3, 7'd63, 11'd2047));
    send_request(load_req(2'd2, 7'd64, 11'd0));
    send_request(access_req(2'd0, 11'd100, 4'd3, 1'b0, 1'b0, 7'd4));
    send_request(access_req(2'd0, 11'd100, 4'd3, 1'b0, 1'b0, 7'd5));
    send_request(access_req(2'd0, 11'd200, 4'd9, 1'b0, 1'b0, 7'd50));
    send_request(access_req(2'd0, 11'd200, 4'd9, 1'b1, 1'b1, 7'd50));
    send_request(access_req(2'd3, 11'd2047, 4'd15, 1'b0, 1'b0, 7'd127));
    send_request(access_req(2'd2, 11'd0, 4'd12, 1'b0, 1'b1, 7'd99));
    send_request(access_req(2'd1, 11'd100, 4'd5, 1'b1, 1'b0, 7'd0));
    send_request(load_req(2'd1, 7'd100, 11'd1234));
  endtask

  // drive one selector up and back down into saturation at zero
  task automatic test_selector_saturation();
    send_request(load_req(2'd1, 7'd70, 11'd40));
    send_request(load_req(2'd1, 7'd10, 11'd41));
    for (int i = 0; i < 40; i++)
      send_request(access_req(2'd1, 11'd40, 4'($urandom), 1'b0, 1'($urandom), 7'd0));
    for (int i = 0; i < 45; i++)
      send_request(access_req(2'd1, 11'd41, 4'($urandom), 1'b0, 1'b0, 7'($urandom)));
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_request(random_req());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_request(random_req());
    wait_drained();
    repeat (20) @(negedge clk);
    for (int i = 0; i < 10; i++) send_request(random_req());
    wait_drained();
  endtask

  task automatic test_selector_high();
    // push cpu 2 past half range so followers act bimodal
    send_idle_pct = 0;
    recv_stall_pct = 10;
    send_request(load_req(2'd2, 7'd90, 11'd300));
    for (int i = 0; i < 530; i++)
      send_request(access_req(2'd2, 11'd300, 4'($urandom), 1'b0, 1'b0, 7'($urandom)));
    for (int i = 0; i < 60; i++)
      send_request(access_req(2'd2, 11'($urandom_range(31)), 4'($urandom),
                              $urandom_range(3) == 0, 1'($urandom), 7'($urandom)));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NCPU*GROUP; i++) begin
      lead_ok[i] = 1'b0;
      lead_set[i] = '0;
    end
    for (int i = 0; i < NCPU; i++) selector[i] = '0;
    for (int s = 0; s < NSET; s++)
      for (int w = 0; w < NWAY; w++) rank[s][w] = 4'(w);
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_selector_saturation();
    wait_drained();
    test_random(300, 0, 0);
    test_random(200, 87, 0);
    test_random(200, 0, 87);
    test_random(200, 28, 28);
    test_backpressure();
    test_selector_high();
    test_random(120, 0, 0);
    wait_drained();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
